FILE: rtl/sdf_pkg.sv
`default_nettype none

package sdf_pkg;

    // Magnitude and BCD sizes: 2^63 needs 19 digits, one spare digit kept
    localparam int MAG_W         = 64;
    localparam int DIGITS        = 20;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int CONV_CNT_W    = $clog2(MAG_W + 1);
    localparam int ND_W          = $clog2(DIGITS + 1);
    localparam int MAX_FIELD_DEF = 64;

    localparam int IN_W  = 80;
    localparam int OUT_W = 8;

    localparam logic [1:0] MODE_LONG  = 2'd1;
    localparam logic [1:0] MODE_SHORT = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int UPC_W = 4;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_CONV,
        OP_NORM,
        OP_ZCNT,
        OP_PADC,
        OP_SPACE,
        OP_SIGN,
        OP_ZERO,
        OP_DIGIT
    } op_t;

    typedef enum logic {
        COND_ALWAYS,
        COND_DONE
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [UPC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic done;
    } status_t;

    // Microprogram: COND_DONE steps hold until the datapath reports done; COND_ALWAYS steps advance
    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            4'd0:    w = '{op: OP_WAIT,  cond: COND_DONE,   target: 4'd1};
            4'd1:    w = '{op: OP_CONV,  cond: COND_DONE,   target: 4'd2};
            4'd2:    w = '{op: OP_NORM,  cond: COND_DONE,   target: 4'd3};
            4'd3:    w = '{op: OP_ZCNT,  cond: COND_ALWAYS, target: 4'd4};
            4'd4:    w = '{op: OP_PADC,  cond: COND_ALWAYS, target: 4'd5};
            4'd5:    w = '{op: OP_SPACE, cond: COND_DONE,   target: 4'd6};
            4'd6:    w = '{op: OP_SIGN,  cond: COND_DONE,   target: 4'd7};
            4'd7:    w = '{op: OP_ZERO,  cond: COND_DONE,   target: 4'd8};
            4'd8:    w = '{op: OP_DIGIT, cond: COND_DONE,   target: 4'd0};
            default: w = '{op: OP_WAIT,  cond: COND_ALWAYS, target: 4'd0};
        endcase
        return w;
    endfunction

    // Double-dabble correction: add 3 to every digit of 5 or more
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int i = 0; i < DIGITS; i++) begin
            if (b[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/signed_decimal_formatter_core.sv
`default_nettype none

// Channel   Dir  Word
// s_*       in   tdata: value[63:0], size_mode[65:64], field_width[72:66],
//                       digit_precision[79:73]
// m_*       out  tdata: character[7:0]; tlast: last character of the item
//
// One item at a time: an accept step, a bit-serial double-dabble conversion, a step
// that strips leading zero digits, the zero-count and padding setup steps, then the
// characters in output segments (spaces, sign, zeros, digits).
// The microcode step counter sets the pace; output stalls hold the emit step.
// rst_n clears the step counter and the output valid; no memory to clear.

module signed_decimal_formatter_core #(
    parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [sdf_pkg::IN_W-1:0]  s_tdata,   // value, size_mode, field_width,
                                                      // digit_precision
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [sdf_pkg::OUT_W-1:0]      m_tdata,   // character
    output logic                           m_tlast
);

    logic [sdf_pkg::UPC_W-1:0]  upc_reg, upc_next;
    sdf_pkg::uword_t            uw;
    sdf_pkg::status_t           status;

    assign uw = sdf_pkg::ucode_rom(upc_reg);

    always_comb
    begin
        if (uw.cond == sdf_pkg::COND_ALWAYS || status.done)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = upc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign s_tready = (uw.op == sdf_pkg::OP_WAIT);

    sdf_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (uw.op),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/sdf_datapath.sv
`default_nettype none

module sdf_datapath #(
    parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sdf_pkg::op_t              op,
    output sdf_pkg::status_t               status,
    input  wire logic                      s_tvalid,
    input  wire logic [sdf_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [sdf_pkg::OUT_W-1:0]      m_tdata,
    output logic                           m_tlast
);

    localparam int CW = $clog2(MAX_FIELD + 1);

    // control-side registers
    logic                            out_valid_reg, out_valid_next;
    logic [sdf_pkg::CONV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [sdf_pkg::ND_W-1:0]        nd_reg, nd_next;
    logic                            neg_reg, neg_next;
    logic                            pgiven_reg, pgiven_next;
    logic [CW-1:0]                   prec_reg, prec_next;
    logic [CW-1:0]                   fw_reg, fw_next;
    logic [CW-1:0]                   zeros_reg, zeros_next;
    logic [CW:0]                     pad_reg, pad_next;
    logic [CW:0]                     rem_reg, rem_next;

    // data registers
    logic [sdf_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic [sdf_pkg::BCD_W-1:0]  bcd_reg, bcd_next;
    logic [7:0]                 char_reg, char_next;
    logic                       last_reg, last_next;

    logic [63:0]     in_value;
    logic [1:0]      in_mode;
    logic [6:0]      in_fw;
    logic [6:0]      in_prec;
    logic [63:0]     sx;
    logic [3:0]      top_dig;
    logic            slot_free;
    logic            is_emit;
    logic [CW:0]     emit_cnt;
    logic [7:0]      emit_ch;
    logic            emit;
    logic [CW-1:0]   nd_ext;
    logic [CW:0]     body;
    logic [sdf_pkg::ND_W-1:0] nd_fix;
    logic [sdf_pkg::BCD_W-1:0] bcd_adj;

    assign in_value = s_tdata[63:0];
    assign in_mode  = s_tdata[65:64];
    assign in_fw    = s_tdata[72:66];
    assign in_prec  = s_tdata[79:73];

    assign top_dig   = bcd_reg[sdf_pkg::BCD_W-1 -: 4];
    assign slot_free = !out_valid_reg || m_tready;
    assign nd_ext    = CW'(nd_reg);
    assign body      = (CW+1)'(nd_ext) + (CW+1)'(zeros_reg) + (CW+1)'(neg_reg);
    assign nd_fix    = (nd_reg == '0 && !(pgiven_reg && prec_reg == '0))
                       ? sdf_pkg::ND_W'(1) : nd_reg;
    assign bcd_adj   = sdf_pkg::dabble(bcd_reg);

    always_comb
    begin
        unique case (in_mode)
            sdf_pkg::MODE_LONG:  sx = in_value;
            sdf_pkg::MODE_SHORT: sx = {{48{in_value[15]}}, in_value[15:0]};
            default:             sx = {{32{in_value[31]}}, in_value[31:0]};
        endcase
    end

    // one character source per emission step
    always_comb
    begin
        is_emit  = 1'b1;
        emit_cnt = '0;
        emit_ch  = sdf_pkg::CH_SPACE;
        unique case (op)
            sdf_pkg::OP_SPACE:
            begin
                emit_cnt = pad_reg;
                emit_ch  = sdf_pkg::CH_SPACE;
            end
            sdf_pkg::OP_SIGN:
            begin
                emit_cnt = (CW+1)'(neg_reg);
                emit_ch  = sdf_pkg::CH_MINUS;
            end
            sdf_pkg::OP_ZERO:
            begin
                emit_cnt = (CW+1)'(zeros_reg);
                emit_ch  = sdf_pkg::CH_ZERO;
            end
            sdf_pkg::OP_DIGIT:
            begin
                emit_cnt = (CW+1)'(nd_reg);
                emit_ch  = sdf_pkg::CH_ZERO + {4'd0, top_dig};
            end
            default:
            begin
                is_emit = 1'b0;
            end
        endcase
    end

    assign emit = is_emit && emit_cnt != '0 && slot_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        nd_next        = nd_reg;
        neg_next       = neg_reg;
        pgiven_next    = pgiven_reg;
        prec_next      = prec_reg;
        fw_next        = fw_reg;
        zeros_next     = zeros_reg;
        pad_next       = pad_reg;
        rem_next       = rem_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        status.done    = 1'b0;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = emit_ch;
            last_next      = (rem_reg == (CW+1)'(1));
            rem_next       = rem_reg - (CW+1)'(1);
        end

        unique case (op)
            sdf_pkg::OP_WAIT:
            begin
                status.done = s_tvalid;
                if (s_tvalid)
                begin
                    neg_next    = sx[63];
                    mag_next    = sx[63] ? (~sx + 64'd1) : sx;
                    bcd_next    = '0;
                    cnt_next    = sdf_pkg::CONV_CNT_W'(sdf_pkg::MAG_W);
                    nd_next     = sdf_pkg::ND_W'(sdf_pkg::DIGITS);
                    fw_next     = (in_fw > 7'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(in_fw);
                    pgiven_next = !in_prec[6];
                    prec_next   = ({1'b0, in_prec[5:0]} > 7'(MAX_FIELD - 1))
                                  ? CW'(MAX_FIELD - 1) : CW'(in_prec[5:0]);
                end
            end
            sdf_pkg::OP_CONV:
            begin
                bcd_next    = {bcd_adj[sdf_pkg::BCD_W-2:0], mag_reg[sdf_pkg::MAG_W-1]};
                mag_next    = {mag_reg[sdf_pkg::MAG_W-2:0], 1'b0};
                cnt_next    = cnt_reg - sdf_pkg::CONV_CNT_W'(1);
                status.done = (cnt_reg == sdf_pkg::CONV_CNT_W'(1));
            end
            sdf_pkg::OP_NORM:
            begin
                // strip leading zero digits, counting what is left
                if (top_dig == 4'd0 && nd_reg != '0)
                begin
                    bcd_next = {bcd_reg[sdf_pkg::BCD_W-5:0], 4'd0};
                    nd_next  = nd_reg - sdf_pkg::ND_W'(1);
                end
                else
                begin
                    status.done = 1'b1;
                end
            end
            sdf_pkg::OP_ZCNT:
            begin
                status.done = 1'b1;
                nd_next     = nd_fix;
                zeros_next  = (pgiven_reg && prec_reg > CW'(nd_fix))
                              ? prec_reg - CW'(nd_fix) : '0;
            end
            sdf_pkg::OP_PADC:
            begin
                status.done = 1'b1;
                pad_next    = ((CW+1)'(fw_reg) > body) ? (CW+1)'(fw_reg) - body : '0;
                rem_next    = ((CW+1)'(fw_reg) > body) ? (CW+1)'(fw_reg) : body;
            end
            sdf_pkg::OP_SPACE:
            begin
                status.done = (emit_cnt == '0);
                if (emit)
                begin
                    pad_next = pad_reg - (CW+1)'(1);
                end
            end
            sdf_pkg::OP_SIGN:
            begin
                status.done = (emit_cnt == '0);
                if (emit)
                begin
                    neg_next = 1'b0;
                end
            end
            sdf_pkg::OP_ZERO:
            begin
                status.done = (emit_cnt == '0);
                if (emit)
                begin
                    zeros_next = zeros_reg - CW'(1);
                end
            end
            sdf_pkg::OP_DIGIT:
            begin
                status.done = (emit_cnt == '0);
                if (emit)
                begin
                    nd_next  = nd_reg - sdf_pkg::ND_W'(1);
                    bcd_next = {bcd_reg[sdf_pkg::BCD_W-5:0], 4'd0};
                end
            end
            default:
            begin
                status.done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            nd_reg        <= '0;
            neg_reg       <= 1'b0;
            pgiven_reg    <= 1'b0;
            prec_reg      <= '0;
            fw_reg        <= '0;
            zeros_reg     <= '0;
            pad_reg       <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            nd_reg        <= nd_next;
            neg_reg       <= neg_next;
            pgiven_reg    <= pgiven_next;
            prec_reg      <= prec_next;
            fw_reg        <= fw_next;
            zeros_reg     <= zeros_next;
            pad_reg       <= pad_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire
